// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define CBE_CHK_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, quiet during reset
`define CBE_CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/cbe_pkg.sv =====
`default_nettype none

package cbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 2 ** FRAC_BITS;
  localparam int HALF      = ONE / 2;

  localparam int X_W   = 17;
  localparam int Y_W   = 19;
  localparam int SMP_W = 17;

  // datapath widths, set by the worst-case curve values
  localparam int ACC_W  = 30;
  localparam int T_W    = 20;
  localparam int PROD_W = ACC_W + T_W;
  localparam int MR_W   = PROD_W - FRAC_BITS;
  localparam int Q_W    = 22;

  localparam int DIV_NW = ACC_W + FRAC_BITS;
  localparam int DIV_DW = ACC_W;
  localparam int DIV_CW = $clog2(DIV_NW);

  localparam int MIN_SLOPE  = (ONE + 500) / 1000;
  localparam int PRECISION  = (ONE + 5000000) / 10000000;
  localparam int T_LIMIT    = 4 * ONE;
  localparam int DIST_LIMIT = 8 * ONE;
  localparam int QMAG_MAX   = 16 * ONE;
  localparam int SMP_MAX    = 2 * ONE - 1;
  localparam int OUT_MIN    = -131072;
  localparam int OUT_MAX    = 196608;

  localparam logic [1:0] REG_X1 = 2'd0;
  localparam logic [1:0] REG_Y1 = 2'd1;
  localparam logic [1:0] REG_X2 = 2'd2;
  localparam logic [1:0] REG_Y2 = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/cbe_mulq.sv =====
`default_nettype none

// shared q-format multiplier, product registered, rounded half up
module cbe_mulq (
  input  wire                                 clk,
  input  wire  signed [cbe_pkg::ACC_W-1:0]    a,
  input  wire  signed [cbe_pkg::T_W-1:0]      b,
  output logic signed [cbe_pkg::MR_W-1:0]     r
);

  logic signed [cbe_pkg::PROD_W-1:0] prod;
  logic signed [cbe_pkg::PROD_W-1:0] rnd;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_comb begin
    rnd = prod + cbe_pkg::PROD_W'(cbe_pkg::HALF);
    r   = rnd[cbe_pkg::PROD_W-1:cbe_pkg::FRAC_BITS];
  end

endmodule

`default_nettype wire

// ===== rtl/cbe_div.sv =====
`default_nettype none

// restoring divider, one quotient bit a cycle
module cbe_div (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              go,
  input  wire  [cbe_pkg::DIV_NW-1:0]       num,
  input  wire  [cbe_pkg::DIV_DW-1:0]       den,
  output cbe_pkg::div_stat_t               stat,
  output logic [cbe_pkg::DIV_NW-1:0]       quo
);

  logic [cbe_pkg::DIV_NW-1:0] nreg;
  logic [cbe_pkg::DIV_DW-1:0] dreg;
  logic [cbe_pkg::DIV_DW-1:0] rem;
  logic [cbe_pkg::DIV_DW:0]   rem_sh;
  logic [cbe_pkg::DIV_DW:0]   rem_next;
  logic                       q_bit;
  logic [cbe_pkg::DIV_CW-1:0] cnt;
  logic                       last;

  always_comb begin
    rem_sh   = {rem, nreg[cbe_pkg::DIV_NW-1]};
    q_bit    = (rem_sh >= {1'b0, dreg});
    rem_next = q_bit ? (rem_sh - {1'b0, dreg}) : rem_sh;
    last     = (cnt == cbe_pkg::DIV_CW'(cbe_pkg::DIV_NW - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      if (go) begin
        stat.busy <= 1'b1;
        stat.done <= 1'b0;
        cnt       <= '0;
        rem       <= '0;
        nreg      <= num;
        dreg      <= den;
      end else if (stat.busy) begin
        rem       <= rem_next[cbe_pkg::DIV_DW-1:0];
        nreg      <= {nreg[cbe_pkg::DIV_NW-2:0], q_bit};
        cnt       <= cnt + cbe_pkg::DIV_CW'(1);
        stat.busy <= !last;
        stat.done <= last;
      end else begin
        stat.done <= 1'b0;
      end
    end
  end

  assign quo = nreg;

endmodule

`default_nettype wire

// ===== rtl/cubic_bezier_ease_top.sv =====
`default_nettype none
// channel   dir  handshake            payload
// in        in   in_valid / in_stall  progress     17b unsigned q16
// out       out  out_valid / out_stall eased_value 19b signed q16
// cfg       in   cfg_wr_en            cfg_index 2b, cfg_data 19b
//
// one item at a time; an item runs the table scan to the first guess, then newton steps or
// bisection steps, then the result; the bit-serial divider and the shared multiplier
// set the time that each of these parts takes
// reset and every register write rebuild the sample table, with in_stall high
// a finished item waits in the output register; the next item is taken meanwhile

`include "assert_macros.svh"

module cubic_bezier_ease_top #(
  parameter int TABLE_SIZE   = 11,
  parameter int NEWTON_STEPS = 4,
  parameter int BISECT_STEPS = 10
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [cbe_pkg::X_W-1:0]          progress,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [cbe_pkg::Y_W-1:0]   eased_value,
  input  wire                              cfg_wr_en,
  input  wire  [1:0]                       cfg_index,
  input  wire  [cbe_pkg::Y_W-1:0]          cfg_data
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int NC_W  = $clog2(NEWTON_STEPS + 1);
  localparam int BC_W  = $clog2(BISECT_STEPS + 1);
  localparam int STEP  = (cbe_pkg::ONE + (TABLE_SIZE - 1) / 2) / (TABLE_SIZE - 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);
  localparam int AW = cbe_pkg::ACC_W;
  localparam int TW = cbe_pkg::T_W;

  typedef enum logic [4:0] {
    S_BUILD, S_HMUL, S_HADD, S_BUILD_WR, S_IDLE, S_SCW, S_SCC, S_DIV, S_INTERP,
    S_GUESS, S_CHK0, S_NT, S_NDIV, S_NUPD, S_BIS, S_BCHK, S_YEVAL, S_YOUT
  } state_t;

  // horner jobs for the shared multiplier
  typedef enum logic [1:0] {K_BEZ, K_SLOPE, K_LIN} kind_t;

  typedef struct packed {
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
    logic signed [AW-1:0] c;
  } coef_set_t;

  state_t state, ret;
  kind_t  kind;
  logic   sel_y;
  logic [1:0] hs;
  logic signed [AW-1:0] acc, sreg;
  logic signed [TW-1:0] tt, tk, tstart, lo, hi;
  logic [cbe_pkg::X_W-1:0] x;
  logic [cbe_pkg::SMP_W-1:0] prev, rdata;
  logic [IDX_W-1:0] rd_addr, j, k;
  logic [NC_W-1:0] nc;
  logic [BC_W-1:0] bc;
  logic div_neg;
  logic [cbe_pkg::X_W-1:0] ctrl_x1, ctrl_x2;
  logic [cbe_pkg::Y_W-1:0] ctrl_y1, ctrl_y2;

  // sample table
  logic [cbe_pkg::SMP_W-1:0] mem [TABLE_SIZE];

  coef_set_t cset_x, cset_y;
  logic signed [AW-1:0] xs, cxv, cmag, hsum, q_acc, den_s, num_s, nd, div_n, div_d;
  logic signed [TW-1:0] mid;
  logic signed [cbe_pkg::MR_W-1:0] mr;
  logic [1:0] hn;
  logic [cbe_pkg::Q_W-2:0] qm;
  logic signed [cbe_pkg::Q_W-1:0] qs;
  logic div_go;
  logic [cbe_pkg::DIV_NW-1:0] quo;
  cbe_pkg::div_stat_t div_st;
  logic [cbe_pkg::SMP_W-1:0] smp;

  function automatic coef_set_t mk_set(input logic signed [AW-1:0] p1,
                                       input logic signed [AW-1:0] p2);
    coef_set_t s;
    logic signed [AW-1:0] t1, t2;
    t1 = (p1 <<< 1) + p1;
    t2 = (p2 <<< 1) + p2;
    s.a = AW'(cbe_pkg::ONE) - t2 + t1;
    s.b = t2 - (t1 <<< 1);
    s.c = t1;
    return s;
  endfunction

  function automatic logic signed [AW-1:0] coef(input coef_set_t cs, input kind_t kd,
                                                input logic [1:0] i,
                                                input logic signed [TW-1:0] ts);
    logic signed [AW-1:0] v;
    v = '0;
    unique case (kd)
      K_BEZ: begin
        unique case (i)
          2'd0: v = cs.a;
          2'd1: v = cs.b;
          2'd2: v = cs.c;
          default: v = '0;
        endcase
      end
      K_SLOPE: begin
        unique case (i)
          2'd0: v = (cs.a <<< 1) + cs.a;
          2'd1: v = cs.b <<< 1;
          2'd2: v = cs.c;
          default: v = '0;
        endcase
      end
      K_LIN: v = AW'(ts);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [AW-1:0] sat(input logic signed [AW-1:0] v,
                                               input int lim_lo, input int lim_hi);
    logic signed [AW-1:0] r;
    r = v;
    if (v < AW'(lim_lo)) r = AW'(lim_lo);
    else if (v > AW'(lim_hi)) r = AW'(lim_hi);
    return r;
  endfunction

  cbe_mulq u_mul (
    .clk (clk),
    .a   (acc),
    .b   (tt),
    .r   (mr)
  );

  cbe_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  ({(div_n[AW-1] ? -div_n : div_n), cbe_pkg::FRAC_BITS'(0)}),
    .den  (div_d[AW-1] ? -div_d : div_d),
    .stat (div_st),
    .quo  (quo)
  );

  always_comb begin
    cset_x = mk_set({{(AW-cbe_pkg::X_W){1'b0}}, ctrl_x1}, {{(AW-cbe_pkg::X_W){1'b0}}, ctrl_x2});
    cset_y = mk_set({{(AW-cbe_pkg::Y_W){ctrl_y1[cbe_pkg::Y_W-1]}}, ctrl_y1},
                    {{(AW-cbe_pkg::Y_W){ctrl_y2[cbe_pkg::Y_W-1]}}, ctrl_y2});
    xs    = {{(AW-cbe_pkg::X_W){1'b0}}, x};
    cxv   = acc - xs;
    cmag  = cxv[AW-1] ? -cxv : cxv;
    hsum  = AW'(mr) + coef(sel_y ? cset_y : cset_x, kind, hs, tstart);
    unique case (kind)
      K_BEZ:   hn = 2'd3;
      K_SLOPE: hn = 2'd2;
      K_LIN:   hn = 2'd1;
      default: hn = 2'd1;
    endcase
    // quotient magnitude held past any value that still matters
    if (quo > cbe_pkg::DIV_NW'(cbe_pkg::QMAG_MAX)) qm = (cbe_pkg::Q_W-1)'(cbe_pkg::QMAG_MAX);
    else qm = quo[cbe_pkg::Q_W-2:0];
    qs    = div_neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    q_acc = AW'(qs);
    den_s = {{(AW-cbe_pkg::SMP_W){1'b0}}, rdata} - {{(AW-cbe_pkg::SMP_W){1'b0}}, prev};
    num_s = xs - {{(AW-cbe_pkg::SMP_W){1'b0}}, prev};
    nd    = AW'(tt) - q_acc;
    mid   = lo + ((hi - lo) >>> 1);
    smp   = cbe_pkg::SMP_W'(sat(acc, 0, cbe_pkg::SMP_MAX));
    // divider launch: interpolation after the scan, or a newton correction
    div_go = 1'b0;
    div_n  = num_s;
    div_d  = den_s;
    if (state == S_SCC && j != '0 && !(j != LAST && rdata <= x) && den_s != '0) begin
      div_go = 1'b1;
    end else if (state == S_NDIV) begin
      div_go = 1'b1;
      div_n  = cxv;
      div_d  = sreg;
    end
  end

  // a register write in the same cycle also holds the item off
  assign in_stall = (state != S_IDLE) || cfg_wr_en;

  always_ff @(posedge clk) begin
    if (state == S_BUILD_WR) mem[k] <= smp;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BUILD;
      k         <= '0;
      tk        <= '0;
      out_valid <= 1'b0;
      ctrl_x1   <= '0;
      ctrl_x2   <= '0;
      ctrl_y1   <= '0;
      ctrl_y2   <= '0;
    end else begin
      // the result register empties once taken (out_stall low), unless a new result lands in it
      if (out_valid && !out_stall && (state != S_YOUT || cfg_wr_en)) out_valid <= 1'b0;
      if (cfg_wr_en) begin
        // a register write restarts the table rebuild
        unique case (cfg_index)
          cbe_pkg::REG_X1: ctrl_x1 <= cfg_data[cbe_pkg::X_W-1:0];
          cbe_pkg::REG_Y1: ctrl_y1 <= cfg_data;
          cbe_pkg::REG_X2: ctrl_x2 <= cfg_data[cbe_pkg::X_W-1:0];
          cbe_pkg::REG_Y2: ctrl_y2 <= cfg_data;
          default: ctrl_x1 <= ctrl_x1;
        endcase
        state <= S_BUILD;
        k     <= '0;
        tk    <= '0;
      end else begin
        unique case (state)
          // table rebuild, one sample per horner pass
          S_BUILD: begin
            tt    <= tk;
            acc   <= coef(cset_x, K_BEZ, 2'd0, tstart);
            kind  <= K_BEZ;
            sel_y <= 1'b0;
            hs    <= 2'd1;
            ret   <= S_BUILD_WR;
            state <= S_HMUL;
          end
          S_BUILD_WR: begin
            if (k == LAST) begin
              state <= S_IDLE;
            end else begin
              k     <= k + IDX_W'(1);
              tk    <= tk + TW'(STEP);
              state <= S_BUILD;
            end
          end
          // shared horner step: acc = round(acc*tt) + next coefficient
          S_HMUL: state <= S_HADD;
          S_HADD: begin
            acc <= hsum;
            if (hs == hn) begin
              state <= ret;
            end else begin
              hs    <= hs + 2'd1;
              state <= S_HMUL;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              x       <= progress;
              rd_addr <= '0;
              j       <= '0;
              state   <= S_SCW;
            end
          end
          // interval scan, one table read per pass through S_SCW and S_SCC
          S_SCW: state <= S_SCC;
          S_SCC: begin
            if (j == '0) begin
              prev    <= rdata;
              tstart  <= '0;
              j       <= IDX_W'(1);
              rd_addr <= IDX_W'(1);
              state   <= S_SCW;
            end else if (j != LAST && rdata <= x) begin
              prev    <= rdata;
              tstart  <= tstart + TW'(STEP);
              j       <= j + IDX_W'(1);
              rd_addr <= j + IDX_W'(1);
              state   <= S_SCW;
            end else if (den_s == '0) begin
              // flat interval: answer at the interval start
              tt    <= tstart;
              state <= S_YEVAL;
            end else begin
              div_neg <= num_s[AW-1] ^ den_s[AW-1];
              ret     <= S_INTERP;
              state   <= S_DIV;
            end
          end
          S_DIV: begin
            if (div_st.done) state <= ret;
          end
          S_INTERP: begin
            acc   <= sat(q_acc, -cbe_pkg::DIST_LIMIT, cbe_pkg::DIST_LIMIT);
            tt    <= TW'(STEP);
            kind  <= K_LIN;
            hs    <= 2'd1;
            ret   <= S_GUESS;
            state <= S_HMUL;
          end
          S_GUESS: begin
            tt    <= TW'(sat(acc, -cbe_pkg::T_LIMIT, cbe_pkg::T_LIMIT));
            acc   <= coef(cset_x, K_SLOPE, 2'd0, tstart);
            kind  <= K_SLOPE;
            sel_y <= 1'b0;
            hs    <= 2'd1;
            ret   <= S_CHK0;
            state <= S_HMUL;
          end
          S_CHK0: begin
            priority if (acc >= AW'(cbe_pkg::MIN_SLOPE)) begin
              nc    <= '0;
              state <= S_NT;
            end else if (acc == '0) begin
              state <= S_YEVAL;
            end else begin
              lo    <= tstart;
              hi    <= tstart + TW'(STEP);
              bc    <= '0;
              state <= S_BIS;
            end
          end
          // newton: slope in acc on entry
          S_NT: begin
            if (acc == '0) begin
              state <= S_YEVAL;
            end else begin
              sreg  <= acc;
              acc   <= coef(cset_x, K_BEZ, 2'd0, tstart);
              kind  <= K_BEZ;
              hs    <= 2'd1;
              ret   <= S_NDIV;
              state <= S_HMUL;
            end
          end
          S_NDIV: begin
            div_neg <= cxv[AW-1] ^ sreg[AW-1];
            ret     <= S_NUPD;
            state   <= S_DIV;
          end
          S_NUPD: begin
            tt <= TW'(sat(nd, -cbe_pkg::T_LIMIT, cbe_pkg::T_LIMIT));
            if (nc == NC_W'(NEWTON_STEPS - 1)) begin
              state <= S_YEVAL;
            end else begin
              nc    <= nc + NC_W'(1);
              acc   <= coef(cset_x, K_SLOPE, 2'd0, tstart);
              kind  <= K_SLOPE;
              hs    <= 2'd1;
              ret   <= S_NT;
              state <= S_HMUL;
            end
          end
          // bisection inside the found interval
          S_BIS: begin
            tt    <= mid;
            acc   <= coef(cset_x, K_BEZ, 2'd0, tstart);
            kind  <= K_BEZ;
            hs    <= 2'd1;
            ret   <= S_BCHK;
            state <= S_HMUL;
          end
          S_BCHK: begin
            if (cxv > 0) hi <= tt;
            else lo <= tt;
            if (cmag > AW'(cbe_pkg::PRECISION) && bc != BC_W'(BISECT_STEPS - 1)) begin
              bc    <= bc + BC_W'(1);
              state <= S_BIS;
            end else begin
              state <= S_YEVAL;
            end
          end
          S_YEVAL: begin
            acc   <= coef(cset_y, K_BEZ, 2'd0, tstart);
            kind  <= K_BEZ;
            sel_y <= 1'b1;
            hs    <= 2'd1;
            ret   <= S_YOUT;
            state <= S_HMUL;
          end
          // hold here until the output register is free
          S_YOUT: begin
            if (!out_valid || !out_stall) begin
              out_valid   <= 1'b1;
              eased_value <= cbe_pkg::Y_W'(sat(acc, cbe_pkg::OUT_MIN, cbe_pkg::OUT_MAX));
              state       <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // divider is running or just finished whenever the sequencer waits on it
  `CBE_CHK_IMPL(a_div_engaged, state == S_DIV, div_st.busy || div_st.done)
  // an accepted item blocks further input
  `CBE_CHK_NEXT(a_item_blocks, in_valid && !in_stall, in_stall)
  // a register write holds off items while the table rebuilds
  `CBE_CHK_NEXT(a_cfg_rebuild, cfg_wr_en, in_stall)
  // results only appear from the final curve evaluation
  `CBE_CHK_IMPL(a_out_source, $rose(out_valid), $past(state == S_YOUT))

endmodule

`default_nettype wire
